// ===== hdl/lz10_pkg.sv =====
package lz10_pkg;

    // History window and derived address width.
    localparam int WINDOW_DEPTH = 4096;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);

    // Field widths.
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 29;
    localparam int LEN_W  = 5;
    localparam int FLAG_CNT_W = 4;

    // Copy length is the upper nibble of the first reference byte plus this bias.
    localparam logic [LEN_W-1:0] LEN_BIAS = LEN_W'(3);
    // Number of token flags carried by one flag byte.
    localparam logic [FLAG_CNT_W-1:0] FLAG_BITS = FLAG_CNT_W'(8);

    // Depth of the command queue between parser and copy engine.
    localparam int CMD_FIFO_DEPTH = 2;

    // Parser phase.
    typedef enum logic [1:0] {
        PH_FLAG,
        PH_TOKEN,
        PH_REF2
    } phase_t;

    // Kind of command handed from the parser to the copy engine.
    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_LIT,
        CMD_COPY
    } cmd_kind_t;

    // Copy engine state.
    typedef enum logic {
        BK_IDLE,
        BK_COPY
    } bk_state_t;

    // One command: a literal, a back-reference copy or a bare stream restart.
    typedef struct packed {
        cmd_kind_t               kind;
        logic [BYTE_W-1:0]       data;     // literal byte
        logic [WIN_AW-1:0]       dist_m1;  // copy distance minus one
        logic [LEN_W-1:0]        count;    // bytes to emit, already clipped
        logic                    hit;      // last byte of this command reaches the limit
        logic                    restart;  // stream ends after this command
    } cmd_t;

endpackage

// ===== hdl/lz10_ram.sv =====
module lz10_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read; the data holds while no read is requested.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/lz10_cmd_fifo.sv =====
module lz10_cmd_fifo import lz10_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t head,
    output logic empty
);

    localparam int PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
    localparam int CNT_QW = $clog2(CMD_FIFO_DEPTH + 1);

    cmd_t              entry_reg [CMD_FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_QW-1:0] count_reg;
    logic [CNT_QW-1:0] count_next;

    assign full  = (count_reg == CNT_QW'(CMD_FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // Pointer and fill count updates; pointers wrap at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_QW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_QW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Command storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hdl/lz10_parser.sv =====
module lz10_parser import lz10_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              in_last,
    input  logic [CNT_W-1:0]  out_size,
    input  logic              fifo_full,
    output logic              push,
    output cmd_t              push_cmd
);

    phase_t                phase_reg;
    phase_t                phase_next;
    logic [BYTE_W-1:0]     flag_reg;
    logic [BYTE_W-1:0]     flag_next;
    logic [FLAG_CNT_W-1:0] bits_left_reg;
    logic [FLAG_CNT_W-1:0] bits_left_next;
    logic [BYTE_W-1:0]     ref_first_reg;
    logic [BYTE_W-1:0]     ref_first_next;
    logic [CNT_W-1:0]      produced_reg;
    logic [CNT_W-1:0]      produced_next;

    logic                  accept;
    logic                  active;
    logic [CNT_W-1:0]      remaining;
    logic [LEN_W-1:0]      ref_len;
    logic                  len_clips;
    logic [LEN_W-1:0]      copy_cnt;
    cmd_t                  cmd;

    assign in_ready = !fifo_full;
    assign accept   = in_valid && in_ready;

    // The parser keeps its own count of bytes that will be produced, so it can
    // clip copies and ignore input once the limit is reached.
    assign active    = (produced_reg < out_size);
    assign remaining = out_size - produced_reg;
    assign ref_len   = LEN_W'(ref_first_reg[BYTE_W-1:4]) + LEN_BIAS;
    assign len_clips = (CNT_W'(ref_len) >= remaining);
    assign copy_cnt  = len_clips ? remaining[LEN_W-1:0] : ref_len;

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            if (active)
            begin
                unique case (phase_reg)
                    PH_FLAG:
                    begin
                        phase_next = PH_TOKEN;
                    end
                    PH_TOKEN:
                    begin
                        if (flag_reg[BYTE_W-1])
                        begin
                            phase_next = PH_REF2;
                        end
                        else if (bits_left_reg != FLAG_CNT_W'(1))
                        begin
                            phase_next = PH_TOKEN;
                        end
                        else
                        begin
                            phase_next = PH_FLAG;
                        end
                    end
                    PH_REF2:
                    begin
                        phase_next = (bits_left_reg != '0) ? PH_TOKEN : PH_FLAG;
                    end
                    default:
                    begin
                        phase_next = PH_FLAG;
                    end
                endcase
            end
            if (in_last)
            begin
                phase_next = PH_FLAG;
            end
        end
    end

    // Token decode, flag bookkeeping and command generation.
    always_comb
    begin
        flag_next      = flag_reg;
        bits_left_next = bits_left_reg;
        ref_first_next = ref_first_reg;
        produced_next  = produced_reg;
        cmd.kind       = CMD_NONE;
        cmd.data       = in_byte;
        cmd.dist_m1    = {ref_first_reg[3:0], in_byte};
        cmd.count      = copy_cnt;
        cmd.hit        = 1'b0;
        cmd.restart    = in_last;
        if (accept)
        begin
            if (active)
            begin
                unique case (phase_reg)
                    PH_TOKEN:
                    begin
                        flag_next      = {flag_reg[BYTE_W-2:0], 1'b0};
                        bits_left_next = bits_left_reg - FLAG_CNT_W'(1);
                        if (flag_reg[BYTE_W-1])
                        begin
                            ref_first_next = in_byte;
                        end
                        else
                        begin
                            cmd.kind      = CMD_LIT;
                            cmd.hit       = (remaining == CNT_W'(1));
                            produced_next = produced_reg + CNT_W'(1);
                        end
                    end
                    PH_REF2:
                    begin
                        cmd.kind      = CMD_COPY;
                        cmd.hit       = len_clips;
                        produced_next = produced_reg + CNT_W'(copy_cnt);
                    end
                    default:
                    begin
                        flag_next      = in_byte;
                        bits_left_next = FLAG_BITS;
                    end
                endcase
            end
            if (in_last)
            begin
                flag_next      = '0;
                bits_left_next = '0;
                ref_first_next = '0;
                produced_next  = '0;
            end
        end
    end

    assign push     = accept && ((cmd.kind != CMD_NONE) || in_last);
    assign push_cmd = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FLAG;
            flag_reg      <= '0;
            bits_left_reg <= '0;
            ref_first_reg <= '0;
            produced_reg  <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            flag_reg      <= flag_next;
            bits_left_reg <= bits_left_next;
            ref_first_reg <= ref_first_next;
            produced_reg  <= produced_next;
        end
    end

endmodule

// ===== hdl/lz10_copy_engine.sv =====
module lz10_copy_engine import lz10_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              head,
    input  logic              q_empty,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              out_last,
    output logic              out_done,
    output logic              ram_we,
    output logic [WIN_AW-1:0] ram_waddr,
    output logic [BYTE_W-1:0] ram_wdata,
    output logic              ram_re,
    output logic [WIN_AW-1:0] ram_raddr,
    input  logic [BYTE_W-1:0] ram_rdata
);

    bk_state_t         state_reg;
    bk_state_t         state_next;
    logic [WIN_AW-1:0] wp_reg;
    logic [CNT_W-1:0]  produced_reg;
    logic [BYTE_W-1:0] last_byte_reg;
    logic [LEN_W-1:0]  remaining_reg;
    logic [WIN_AW-1:0] dist_m1_reg;
    logic              hit_reg;
    logic              restart_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;
    logic              out_done_reg;

    logic              can_load;
    logic              emit;
    logic [BYTE_W-1:0] emit_byte;
    logic              emit_last;
    logic              emit_done;
    logic              restart;
    logic              load_copy;
    logic              copy_last;
    logic              src_valid;
    logic [BYTE_W-1:0] copy_byte;
    logic [WIN_AW-1:0] rd_base;
    logic [WIN_AW-1:0] rd_dist_m1;

    // The output register can take a byte when empty or being drained.
    assign can_load  = !out_valid_reg || out_ready;
    assign copy_last = (remaining_reg == LEN_W'(1));

    // A source byte is real only when it lies inside the current stream;
    // distance one repeats the byte just emitted, which is still being written.
    assign src_valid = (CNT_W'(dist_m1_reg) < produced_reg);
    assign copy_byte = !src_valid ? '0
                     : (dist_m1_reg == '0) ? last_byte_reg : ram_rdata;

    // Read address: write position minus distance, one ahead while copying.
    assign rd_base    = (state_reg == BK_COPY) ? wp_reg + WIN_AW'(1) : wp_reg;
    assign rd_dist_m1 = (state_reg == BK_COPY) ? dist_m1_reg : head.dist_m1;
    assign ram_raddr  = rd_base + ~rd_dist_m1;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty && (head.kind == CMD_COPY))
                begin
                    state_next = BK_COPY;
                end
            end
            BK_COPY:
            begin
                if (can_load && copy_last)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Command execution.
    always_comb
    begin
        pop       = 1'b0;
        emit      = 1'b0;
        emit_byte = copy_byte;
        emit_last = copy_last;
        emit_done = copy_last && hit_reg;
        restart   = 1'b0;
        load_copy = 1'b0;
        ram_re    = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    unique case (head.kind)
                        CMD_LIT:
                        begin
                            if (can_load)
                            begin
                                pop       = 1'b1;
                                emit      = 1'b1;
                                emit_byte = head.data;
                                emit_last = 1'b1;
                                emit_done = head.hit;
                                restart   = head.restart;
                            end
                        end
                        CMD_COPY:
                        begin
                            pop       = 1'b1;
                            load_copy = 1'b1;
                            ram_re    = 1'b1;
                        end
                        default:
                        begin
                            pop     = 1'b1;
                            restart = head.restart;
                        end
                    endcase
                end
            end
            BK_COPY:
            begin
                if (can_load)
                begin
                    emit = 1'b1;
                    if (copy_last)
                    begin
                        restart = restart_reg;
                    end
                    else
                    begin
                        ram_re = 1'b1;
                    end
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // Every emitted byte goes into the history window.
    assign ram_we    = emit;
    assign ram_waddr = wp_reg;
    assign ram_wdata = emit_byte;

    // Control state and stream position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            wp_reg        <= '0;
            produced_reg  <= '0;
            remaining_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (restart)
            begin
                wp_reg       <= '0;
                produced_reg <= '0;
            end
            else if (emit)
            begin
                wp_reg       <= wp_reg + WIN_AW'(1);
                produced_reg <= produced_reg + CNT_W'(1);
            end
            if (load_copy)
            begin
                remaining_reg <= head.count;
            end
            else if (emit && (state_reg == BK_COPY))
            begin
                remaining_reg <= remaining_reg - LEN_W'(1);
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Copy parameters and output payload.
    always_ff @(posedge clk)
    begin
        if (load_copy)
        begin
            dist_m1_reg <= head.dist_m1;
            hit_reg     <= head.hit;
            restart_reg <= head.restart;
        end
        if (emit)
        begin
            last_byte_reg <= emit_byte;
            out_byte_reg  <= emit_byte;
            out_last_reg  <= emit_last;
            out_done_reg  <= emit_done;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign out_done  = out_done_reg;

    // A copy in progress always has bytes left to emit.
    a_copy_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_COPY) |-> (remaining_reg != '0))
        else $error("copy engine busy with no bytes left");

    // The window read must not advance while the output is stalled.
    a_no_read_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == BK_COPY) && !can_load) |-> !ram_re)
        else $error("window read advanced during output stall");

    // Commands are taken only between copies.
    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == BK_IDLE))
        else $error("command taken while copying");

    // Every new output byte was also written to the window.
    a_out_written: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ram_we))
        else $error("output byte not recorded in history");

endmodule

// ===== hdl/lz10_decompressor_core.sv =====
// A literal passes through the command queue and the output register before it is on the output.
// After the second byte of a back reference, the copy engine takes the command and issues the first
// registered window read, then emits one byte per cycle while the output is not stalled. Flag bytes
// and first reference bytes give no command; the parser takes input while the queue is not full.
// Reset is asynchronous and active low; it clears control state. The history window is not
// cleared: only bytes written in the current stream are ever read, older ones read as zero.
module lz10_decompressor_core import lz10_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] in_byte
    input  logic              s_axis_tlast,   // in_last
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // [7:0] out_byte
    output logic              m_axis_tlast,   // out_last
    output logic              m_axis_tuser,   // [0] out_done
    input  logic              cfg_wr_en,
    input  logic [CNT_W-1:0]  cfg_wr_data     // out_size
);

    logic [CNT_W-1:0]  out_size_reg;
    logic              fifo_full;
    logic              fifo_empty;
    logic              push;
    logic              pop;
    cmd_t              push_cmd;
    cmd_t              head;
    logic              ram_we;
    logic [WIN_AW-1:0] ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [WIN_AW-1:0] ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    // Output size limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_size_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            out_size_reg <= cfg_wr_data;
        end
    end

    // Front: token parser.
    lz10_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .out_size  (out_size_reg),
        .fifo_full (fifo_full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    // Command queue between parser and copy engine.
    lz10_cmd_fifo u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (fifo_full),
        .pop      (pop),
        .head     (head),
        .empty    (fifo_empty)
    );

    // Back: literal output and back-reference copy.
    lz10_copy_engine u_copy_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (fifo_empty),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_done  (m_axis_tuser),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // History window.
    lz10_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
